// ===== src/composite_mass_property_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Composite mass property accumulator: assertion macros
// Concurrent checks on clk, disabled during rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef COMPOSITE_MASS_PROPERTY_ACCUMULATOR_DEFINES_SVH
`define COMPOSITE_MASS_PROPERTY_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CMPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmpa assertion failed");
`define CMPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmpa assertion failed");
`else
`define CMPA_ASSERT_IMP(lbl, ante, cons)
`define CMPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/cmpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cmpa_pkg
// Types, widths and codes of the composite mass property accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmpa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MASS_W    = 31;
  localparam int VAL_W     = 32;
  localparam int MAG_W     = VAL_W + 1;
  localparam int PROD_W    = MAG_W + VAL_W;
  localparam int DW_W      = 63 - FRAC_BITS;
  localparam int TACC_W    = 97 - FRAC_BITS;
  localparam int TRM_W     = 62;
  localparam int DIV_N     = 64;
  localparam int CNT_W     = 6;

  typedef struct packed {
    logic                     start_new;
    logic [MASS_W-1:0]        part_mass;
    logic signed [VAL_W-1:0]  part_x;
    logic signed [VAL_W-1:0]  part_y;
    logic signed [VAL_W-1:0]  part_z;
    logic signed [VAL_W-1:0]  part_ixx;
    logic signed [VAL_W-1:0]  part_ixy;
    logic signed [VAL_W-1:0]  part_ixz;
    logic signed [VAL_W-1:0]  part_iyy;
    logic signed [VAL_W-1:0]  part_iyz;
    logic signed [VAL_W-1:0]  part_izz;
  } in_item_t;

  typedef struct packed {
    logic [MASS_W-1:0]        total_mass;
    logic [MASS_W-1:0]        inverse_mass;
    logic signed [VAL_W-1:0]  center_x;
    logic signed [VAL_W-1:0]  center_y;
    logic signed [VAL_W-1:0]  center_z;
    logic signed [VAL_W-1:0]  body_ixx;
    logic signed [VAL_W-1:0]  body_ixy;
    logic signed [VAL_W-1:0]  body_ixz;
    logic signed [VAL_W-1:0]  body_iyy;
    logic signed [VAL_W-1:0]  body_iyz;
    logic signed [VAL_W-1:0]  body_izz;
    logic                     saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WMUL, S_WACC, S_MASS, S_ZERO, S_DIVI, S_DIVS, S_DIVW,
    S_DMUL, S_DACC, S_TMUL, S_TACC, S_TWR, S_SUM, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WMUL, OP_WACC, OP_MASS, OP_ZERO, OP_DIVI, OP_DIVS,
    OP_DIVW, OP_DMUL, OP_DACC, OP_TMUL, OP_TACC, OP_TWR, OP_SUM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
    logic       half;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic mass_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/cmpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmpa_ctrl
// Sequencer: steps the datapath through products, divisions and sums.
// ----------------------------------------------------------------------------
`default_nettype none
`include "composite_mass_property_accumulator_defines.svh"

module cmpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cmpa_pkg::stat_t stat,
  output cmpa_pkg::cmd_t  cmd
);
  import cmpa_pkg::*;

  state_t           state, state_next;
  logic [2:0]       k, k_next;
  logic             half, half_next;
  logic [CNT_W-1:0] bitcnt, bitcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      k      <= '0;
      half   <= 1'b0;
      bitcnt <= '0;
    end else begin
      state  <= state_next;
      k      <= k_next;
      half   <= half_next;
      bitcnt <= bitcnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    k_next      = k;
    half_next   = half;
    bitcnt_next = bitcnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WMUL;
          k_next     = '0;
        end
      end
      S_WMUL: state_next = S_WACC;
      S_WACC: begin
        if (k == 3'd5) begin
          state_next = S_MASS;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_WMUL;
        end
      end
      S_MASS: begin
        k_next     = '0;
        state_next = stat.mass_zero ? S_ZERO : S_DIVI;
      end
      S_ZERO: begin
        k_next     = '0;
        state_next = S_DMUL;
      end
      S_DIVI: begin
        bitcnt_next = '0;
        state_next  = S_DIVS;
      end
      S_DIVS: begin
        if (bitcnt == CNT_W'(DIV_N - 1)) begin
          state_next = S_DIVW;
        end else begin
          bitcnt_next = bitcnt + CNT_W'(1);
        end
      end
      S_DIVW: begin
        if (k == 3'd3) begin
          k_next     = '0;
          state_next = S_DMUL;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_DIVI;
        end
      end
      S_DMUL: state_next = S_DACC;
      S_DACC: begin
        if (k == 3'd2) begin
          k_next     = '0;
          half_next  = 1'b0;
          state_next = S_TMUL;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_DMUL;
        end
      end
      S_TMUL: state_next = S_TACC;
      S_TACC: begin
        if (!half) begin
          half_next  = 1'b1;
          state_next = S_TMUL;
        end else begin
          state_next = S_TWR;
        end
      end
      S_TWR: begin
        half_next = 1'b0;
        if (k == 3'd5) begin
          k_next     = '0;
          state_next = S_SUM;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_TMUL;
        end
      end
      S_SUM: begin
        if (k == 3'd5) begin
          state_next = S_OUT;
        end else begin
          k_next = k + 3'd1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.idx  = k;
    cmd.half = half;
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_WMUL: cmd.op = OP_WMUL;
      S_WACC: cmd.op = OP_WACC;
      S_MASS: cmd.op = OP_MASS;
      S_ZERO: cmd.op = OP_ZERO;
      S_DIVI: cmd.op = OP_DIVI;
      S_DIVS: cmd.op = OP_DIVS;
      S_DIVW: cmd.op = OP_DIVW;
      S_DMUL: cmd.op = OP_DMUL;
      S_DACC: cmd.op = OP_DACC;
      S_TMUL: cmd.op = OP_TMUL;
      S_TACC: cmd.op = OP_TACC;
      S_TWR:  cmd.op = OP_TWR;
      S_SUM:  cmd.op = OP_SUM;
      S_OUT:  cmd.op = stat.out_free ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  `CMPA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `CMPA_ASSERT_IMP(a_out_slot_free, cmd.op == OP_OUT, stat.out_free)
  `CMPA_ASSERT_NXT(a_div_runs, state == S_DIVS, (state == S_DIVS) || (state == S_DIVW))
  `CMPA_ASSERT_NXT(a_zero_mass_path, (state == S_MASS) && stat.mass_zero, state == S_ZERO)

endmodule

`default_nettype wire

// ===== src/cmpa_datapath.sv =====
// ----------------------------------------------------------------------------
// cmpa_datapath
// Body state, shared multiplier, radix-2 divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmpa_datapath (
  input  logic                clk,
  input  logic                rst,
  input  cmpa_pkg::in_item_t  in_item,
  input  cmpa_pkg::cmd_t      cmd,
  input  logic                out_ready,
  output cmpa_pkg::stat_t     stat,
  output logic                out_valid,
  output cmpa_pkg::out_item_t out_item
);
  import cmpa_pkg::*;

  localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
  localparam logic [TACC_W-1:0] PCLAMP   = TACC_W'(1) << 60;
  localparam logic [63:0]       INV_NUM  = 64'(1) << (2 * FRAC_BITS);

  function automatic logic [MAG_W-1:0] mag33(logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic [VAL_W:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // product terms: 0 d1*dw1, 1 d2*dw2, 2 d0*dw1, 3 d0*dw2, 4 d0*dw0, 5 d1*dw2
  function automatic logic [1:0] term_a(logic [2:0] j);
    case (j)
      3'd0: return 2'd1;
      3'd1: return 2'd2;
      3'd5: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] term_b(logic [2:0] j);
    case (j)
      3'd0: return 2'd1;
      3'd1: return 2'd2;
      3'd2: return 2'd1;
      3'd3: return 2'd2;
      3'd5: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  in_item_t                pk;
  logic [MASS_W-1:0]       sum_mass;
  logic signed [VAL_W-1:0] cen [3];
  logic signed [VAL_W-1:0] it [6];
  logic [MASS_W-1:0]       inv;
  logic                    sat;
  logic signed [63:0]      w [3];
  logic [DW_W-1:0]         dwm [3];
  logic                    dwn [3];
  logic [PROD_W-1:0]       prod;
  logic                    prod_neg;
  logic [TACC_W-1:0]       tacc;
  logic signed [TRM_W-1:0] t [6];
  logic [MASS_W-1:0]       div_rem;
  logic [63:0]             div_q;

  logic signed [VAL_W-1:0] pv [3];
  logic signed [VAL_W-1:0] pin [6];
  logic signed [MAG_W-1:0] d [3];
  logic [MAG_W-1:0]        a_mag;
  logic [VAL_W-1:0]        b_mag;
  logic                    m_neg;
  logic [1:0]              ix, jx, ta, tb;
  logic signed [63:0]      w_term;
  logic [VAL_W:0]          msum;
  logic [VAL_W:0]          trial;
  logic                    ge;
  logic [2:0]              wsel;
  logic [TACC_W-1:0]       tsh;
  logic [60:0]             tmag;
  logic signed [63:0]      nt;
  logic [VAL_W:0]          ntc;

  assign pv[0]  = pk.part_x;
  assign pv[1]  = pk.part_y;
  assign pv[2]  = pk.part_z;
  assign pin[0] = pk.part_ixx;
  assign pin[1] = pk.part_ixy;
  assign pin[2] = pk.part_ixz;
  assign pin[3] = pk.part_iyy;
  assign pin[4] = pk.part_iyz;
  assign pin[5] = pk.part_izz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = MAG_W'(cen[i]) - MAG_W'(pv[i]);
    end
  end

  assign ix   = cmd.idx[1:0];
  assign jx   = 2'(cmd.idx - 3'd3);
  assign ta   = term_a(cmd.idx);
  assign tb   = term_b(cmd.idx);
  assign wsel = cmd.idx - 3'd1;

  always_comb begin
    a_mag = '0;
    b_mag = '0;
    m_neg = 1'b0;
    case (cmd.op)
      OP_WMUL: begin
        if (cmd.idx < 3'd3) begin
          a_mag = mag33(MAG_W'(cen[ix]));
          b_mag = VAL_W'(sum_mass);
          m_neg = cen[ix][VAL_W-1];
        end else begin
          a_mag = mag33(MAG_W'(pv[jx]));
          b_mag = VAL_W'(pk.part_mass);
          m_neg = pv[jx][VAL_W-1];
        end
      end
      OP_DMUL: begin
        a_mag = mag33(d[ix]);
        b_mag = VAL_W'(pk.part_mass);
        m_neg = d[ix][MAG_W-1];
      end
      OP_TMUL: begin
        a_mag = mag33(d[ta]);
        b_mag = cmd.half ? VAL_W'(dwm[tb][DW_W-1:VAL_W]) : dwm[tb][VAL_W-1:0];
        m_neg = d[ta][MAG_W-1] ^ dwn[tb];
      end
      default: ;
    endcase
  end

  assign w_term = prod_neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  assign msum   = VAL_W'(sum_mass) + VAL_W'(pk.part_mass);
  assign trial  = {1'b0, div_rem, div_q[63]};
  assign ge     = trial >= (VAL_W+1)'(sum_mass);
  assign tsh    = tacc >> FRAC_BITS;
  assign tmag   = (tsh > PCLAMP) ? PCLAMP[60:0] : tsh[60:0];

  always_comb begin
    nt = 64'(it[cmd.idx]) + 64'(pin[cmd.idx]);
    case (cmd.idx)
      3'd0: nt = nt + 64'(t[0]) + 64'(t[1]);
      3'd1: nt = nt - 64'(t[2]);
      3'd2: nt = nt - 64'(t[3]);
      3'd3: nt = nt + 64'(t[4]) + 64'(t[1]);
      3'd4: nt = nt - 64'(t[5]);
      3'd5: nt = nt + 64'(t[4]) + 64'(t[0]);
      default: ;
    endcase
    ntc = clip32(nt);
  end

  // body state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_mass  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) cen[i] <= '0;
      for (int i = 0; i < 6; i++) it[i] <= '0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (in_item.start_new) begin
            sum_mass <= '0;
            for (int i = 0; i < 3; i++) cen[i] <= '0;
            for (int i = 0; i < 6; i++) it[i] <= '0;
          end
        end
        OP_MASS: sum_mass <= msum[VAL_W-1] ? MASS_MAX : msum[MASS_W-1:0];
        OP_ZERO: for (int i = 0; i < 3; i++) cen[i] <= '0;
        OP_DIVW: begin
          if (cmd.idx != 3'd0) begin
            if (w[wsel[1:0]][63]) begin
              cen[wsel[1:0]] <= (div_q > 64'h8000_0000) ? 32'h8000_0000
                                                       : 32'(~div_q + 64'd1);
            end else begin
              cen[wsel[1:0]] <= (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                       : div_q[31:0];
            end
          end
        end
        OP_SUM: it[cmd.idx] <= ntc[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pk  <= in_item;
        sat <= 1'b0;
      end
      OP_WMUL, OP_DMUL, OP_TMUL: begin
        prod     <= PROD_W'(a_mag) * PROD_W'(b_mag);
        prod_neg <= m_neg;
      end
      OP_WACC: begin
        if (cmd.idx < 3'd3) w[ix] <= w_term;
        else w[jx] <= w[jx] + w_term;
      end
      OP_MASS: if (msum[VAL_W-1]) sat <= 1'b1;
      OP_ZERO: inv <= '0;
      OP_DIVI: begin
        div_rem <= '0;
        if (cmd.idx == 3'd0) div_q <= INV_NUM;
        else div_q <= w[wsel[1:0]][63] ? (~w[wsel[1:0]] + 64'd1) : w[wsel[1:0]];
      end
      OP_DIVS: begin
        div_rem <= ge ? MASS_W'(trial - (VAL_W+1)'(sum_mass)) : trial[MASS_W-1:0];
        div_q   <= {div_q[62:0], ge};
      end
      OP_DIVW: begin
        if (cmd.idx == 3'd0) begin
          if (div_q > 64'(MASS_MAX)) begin
            inv <= MASS_MAX;
            sat <= 1'b1;
          end else begin
            inv <= div_q[MASS_W-1:0];
          end
        end else if (w[wsel[1:0]][63]) begin
          if (div_q > 64'h8000_0000) sat <= 1'b1;
        end else begin
          if (div_q > 64'h7FFF_FFFF) sat <= 1'b1;
        end
      end
      OP_DACC: begin
        dwm[ix] <= prod[FRAC_BITS +: DW_W];
        dwn[ix] <= prod_neg;
      end
      OP_TACC: begin
        if (!cmd.half) tacc <= TACC_W'(prod);
        else tacc <= tacc + (TACC_W'(prod) << VAL_W);
      end
      OP_TWR: begin
        t[cmd.idx] <= prod_neg ? -$signed(TRM_W'(tmag)) : $signed(TRM_W'(tmag));
      end
      OP_SUM: if (ntc[VAL_W]) sat <= 1'b1;
      OP_OUT: begin
        out_item.total_mass   <= sum_mass;
        out_item.inverse_mass <= inv;
        out_item.center_x     <= cen[0];
        out_item.center_y     <= cen[1];
        out_item.center_z     <= cen[2];
        out_item.body_ixx     <= it[0];
        out_item.body_ixy     <= it[1];
        out_item.body_ixz     <= it[2];
        out_item.body_iyy     <= it[3];
        out_item.body_iyz     <= it[4];
        out_item.body_izz     <= it[5];
        out_item.saturated    <= sat;
      end
      default: ;
    endcase
  end

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.mass_zero = (sum_mass == '0) && (pk.part_mass == '0);

endmodule

`default_nettype wire

// ===== src/composite_mass_property_accumulator.sv =====
// ----------------------------------------------------------------------------
// composite_mass_property_accumulator
// Adds parts to a running body: mass, inverse mass, centroid, inertia.
//
//   channel  signals                       payload
//   in       in_valid / in_ready           in_item  (in_item_t)
//   out      out_valid / out_ready         out_item (out_item_t)
//
// Each item runs four 64-step divisions on the shared radix-2 divider
// (skipped when the total mass is zero) and 21 passes through one
// shared 33x32 multiplier.
// Reset clears mass, centroid and inertia.
// A new item is taken while a result still waits; only the final write
// to the output register waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module composite_mass_property_accumulator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmpa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cmpa_pkg::out_item_t out_item
);
  import cmpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cmpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cmpa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
